@@ rtl/core/binary_gcd_defines.svh @@
// Assertion macros shared by the binary GCD RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef BINARY_GCD_DEFINES_SVH
`define BINARY_GCD_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every edge outside reset.
`define BGCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent this cycle implies consequent on the next edge.
`define BGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BGCD_ASSERT(lbl, clk, rst, prop, msg)
`define BGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/bgcd_pkg.sv @@
`timescale 1ns / 1ps

package bgcd_pkg;

   // Width of the operand and result ports
   localparam int FIELD_WIDTH = 32;

   // Control that travels with each pipeline stage
   typedef struct packed {
      logic valid;  // stage holds a transaction
      logic done;   // second value has reached zero, p holds the gcd less the shared power of two
   } stage_ctl_type;

   // Operation one stage applies to its pair
   typedef enum logic [2:0] {
      OP_HOLD       = 3'd0,
      OP_SHIFT_BOTH = 3'd1,
      OP_SHIFT_P    = 3'd2,
      OP_SHIFT_Q    = 3'd3,
      OP_SUBTRACT   = 3'd4
   } step_op_type;

endpackage

@@ rtl/core/bgcd_step.sv @@
`timescale 1ns / 1ps
`include "binary_gcd_defines.svh"

module bgcd_step #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bgcd_pkg::stage_ctl_type             in_ctl,
   input  logic [DATA_WIDTH-1:0]               in_p,
   input  logic [DATA_WIDTH-1:0]               in_q,
   input  logic [$clog2(DATA_WIDTH)-1:0]       in_shared,
   output bgcd_pkg::stage_ctl_type             out_ctl,
   output logic [DATA_WIDTH-1:0]               out_p,
   output logic [DATA_WIDTH-1:0]               out_q,
   output logic [$clog2(DATA_WIDTH)-1:0]       out_shared
);
   import bgcd_pkg::*;

   localparam int SHARED_WIDTH = $clog2(DATA_WIDTH);

   step_op_type             op;
   logic                    p_gt_q;
   logic [DATA_WIDTH-1:0]   diff;
   logic                    ctl_done_in;
   logic [DATA_WIDTH-1:0]   p_in;
   logic [DATA_WIDTH-1:0]   q_in;
   logic [SHARED_WIDTH-1:0] shared_in;
   logic                    valid_ff;
   logic                    done_ff;
   logic [DATA_WIDTH-1:0]   p_ff;
   logic [DATA_WIDTH-1:0]   q_ff;
   logic [SHARED_WIDTH-1:0] shared_ff;

   // pick one step from the parity of the pair, or hold an empty or finished stage
   always_comb begin
      priority if (!in_ctl.valid || in_ctl.done) begin
         op = OP_HOLD;
      end else if (!in_p[0] && !in_q[0]) begin
         op = OP_SHIFT_BOTH;
      end else if (!in_p[0]) begin
         op = OP_SHIFT_P;
      end else if (!in_q[0]) begin
         op = OP_SHIFT_Q;
      end else begin
         op = OP_SUBTRACT;
      end
   end

   // both odd: larger minus smaller, always even
   assign p_gt_q = in_p > in_q;
   assign diff   = p_gt_q ? (in_p - in_q) : (in_q - in_p);

   always_comb begin
      p_in        = in_p;
      q_in        = in_q;
      shared_in   = in_shared;
      ctl_done_in = in_ctl.done;
      unique case (op)
         OP_HOLD: begin
         end
         OP_SHIFT_BOTH: begin
            p_in      = in_p >> 1;
            q_in      = in_q >> 1;
            shared_in = in_shared + SHARED_WIDTH'(1);
         end
         OP_SHIFT_P: begin
            p_in = in_p >> 1;
         end
         OP_SHIFT_Q: begin
            q_in = in_q >> 1;
         end
         OP_SUBTRACT: begin
            // difference is even, so its first halving is folded in here
            p_in        = p_gt_q ? in_q : in_p;
            q_in        = diff >> 1;
            ctl_done_in = (diff == '0);
         end
         default: begin
         end
      endcase
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
      done_ff   <= ctl_done_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      shared_ff <= shared_in;
   end

   assign out_ctl.valid = valid_ff;
   assign out_ctl.done  = done_ff;
   assign out_p         = p_ff;
   assign out_q         = q_ff;
   assign out_shared    = shared_ff;

   `BGCD_ASSERT_NEXT(a_sub_keeps_p_odd, clock, reset, op == OP_SUBTRACT, out_p[0],
      "subtract step left an even p")
   `BGCD_ASSERT_NEXT(a_done_holds_p, clock, reset, in_ctl.valid && in_ctl.done,
      out_ctl.done && (out_p == $past(in_p)), "finished pair changed")

endmodule

@@ rtl/core/binary_gcd.sv @@
`timescale 1ns / 1ps
// Binary GCD, one step of the binary algorithm per pipeline stage.
// A taken start passes the entry register, the step stages and the output register to rsp_valid.
// Throughput: one transaction per cycle while busy is low; the 2*DATA_WIDTH step stages bound the work.
// Reset: synchronous, clears all stage valid bits; busy is registered and stays high until an edge samples reset low.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "binary_gcd_defines.svh"

module binary_gcd #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bgcd_pkg::FIELD_WIDTH-1:0] req_operand_a,
   input  logic [bgcd_pkg::FIELD_WIDTH-1:0] req_operand_b,
   output logic                            rsp_valid,
   output logic [bgcd_pkg::FIELD_WIDTH-1:0] rsp_divisor
);
   import bgcd_pkg::*;

   localparam int SHARED_WIDTH = $clog2(DATA_WIDTH);
   // every step removes at least one bit from the pair
   localparam int STAGES       = 2 * DATA_WIDTH;
   localparam int LATENCY      = STAGES + 2;

   logic                    accept;
   logic [DATA_WIDTH-1:0]   a_w;
   logic [DATA_WIDTH-1:0]   b_w;
   logic                    zero_operand;
   logic                    busy_ff;

   stage_ctl_type           ctl_w    [STAGES+1];
   logic [DATA_WIDTH-1:0]   p_w      [STAGES+1];
   logic [DATA_WIDTH-1:0]   q_w      [STAGES+1];
   logic [SHARED_WIDTH-1:0] shared_w [STAGES+1];

   logic                    entry_valid_ff;
   logic                    entry_done_ff;
   logic [DATA_WIDTH-1:0]   entry_p_ff;
   logic [DATA_WIDTH-1:0]   entry_q_ff;

   logic [DATA_WIDTH-1:0]   result_in;
   logic [FIELD_WIDTH-1:0]  divisor_in;
   logic                    rsp_valid_ff;
   logic [FIELD_WIDTH-1:0]  rsp_divisor_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // fit ports to the datapath width
   assign a_w        = DATA_WIDTH'(req_operand_a);
   assign b_w        = DATA_WIDTH'(req_operand_b);
   assign divisor_in = FIELD_WIDTH'(result_in);

   // a zero operand finishes at once with the other operand
   assign zero_operand = (a_w == '0) || (b_w == '0);

   // busy only around reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= accept;
      end
      entry_done_ff <= zero_operand;
      entry_p_ff    <= zero_operand ? (a_w | b_w) : a_w;
      entry_q_ff    <= zero_operand ? '0 : b_w;
   end

   assign ctl_w[0].valid = entry_valid_ff;
   assign ctl_w[0].done  = entry_done_ff;
   assign p_w[0]         = entry_p_ff;
   assign q_w[0]         = entry_q_ff;
   assign shared_w[0]    = '0;

   // step stages
   for (genvar i = 0; i < STAGES; i++) begin : g_step
      bgcd_step #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .in_ctl     (ctl_w[i]),
         .in_p       (p_w[i]),
         .in_q       (q_w[i]),
         .in_shared  (shared_w[i]),
         .out_ctl    (ctl_w[i+1]),
         .out_p      (p_w[i+1]),
         .out_q      (q_w[i+1]),
         .out_shared (shared_w[i+1])
      );
   end

   // restore the shared power of two
   assign result_in = p_w[STAGES] << shared_w[STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_w[STAGES].valid;
      end
      rsp_divisor_ff <= divisor_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = rsp_divisor_ff;

   `BGCD_ASSERT(a_last_stage_done, clock, reset,
      !ctl_w[STAGES].valid || (ctl_w[STAGES].done && (q_w[STAGES] == '0)),
      "pair not finished at pipeline end")
   `BGCD_ASSERT(a_fixed_latency, clock, reset, accept |-> ##LATENCY rsp_valid,
      "result missing after fixed latency")
   `BGCD_ASSERT(a_no_spurious_rsp, clock, reset, rsp_valid |-> $past(accept, LATENCY),
      "result without a matching transaction")

endmodule

@@ sim/gcd_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and response channels of binary_gcd, predicts each
// divisor and compares it against what the block returns.
module gcd_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [bgcd_pkg::FIELD_WIDTH-1:0] req_operand_a,
   input  logic [bgcd_pkg::FIELD_WIDTH-1:0] req_operand_b,
   input  logic                             rsp_valid,
   input  logic [bgcd_pkg::FIELD_WIDTH-1:0] rsp_divisor,
   output int                               accepted_count,
   output int                               outstanding,
   output int                               mismatch_count
);

   localparam int W = bgcd_pkg::FIELD_WIDTH;

   // divisors predicted for accepted transactions, oldest first
   logic [W-1:0] expected_divisors[$];

   // binary GCD on the operand pair
   function automatic logic [W-1:0] stein_gcd(input logic [W-1:0] a_in,
                                              input logic [W-1:0] b_in);
      logic [W-1:0] p;
      logic [W-1:0] q;
      logic [W-1:0] swap;
      logic [W-1:0] both;
      int shared;
      p = a_in;
      q = b_in;
      shared = 0;
      if (p == '0) return q;
      if (q == '0) return p;
      // common power of two
      both = p | q;
      while (both[0] == 1'b0) begin
         both = both >> 1;
         shared++;
      end
      while (p[0] == 1'b0) p = p >> 1;
      do begin
         while (q[0] == 1'b0) q = q >> 1;
         if (p > q) begin
            swap = p;
            p = q;
            q = swap;
         end
         q = q - p;
      end while (q != '0);
      return p << shared;
   endfunction

   initial begin
      accepted_count = 0;
      outstanding = 0;
      mismatch_count = 0;
   end

   always @(posedge clock) begin
      logic [W-1:0] want;
      int misses;
      misses = mismatch_count;
      if (!reset) begin
         // new transaction taken at this edge
         if (start && !busy) begin
            expected_divisors.push_back(stein_gcd(req_operand_a, req_operand_b));
            accepted_count <= accepted_count + 1;
         end
         // result strobe
         if (rsp_valid) begin
            if (expected_divisors.size() == 0) begin
               if (misses < 10)
                  $display("%0t: unexpected result divisor=%h", $realtime, rsp_divisor);
               misses++;
            end else begin
               want = expected_divisors.pop_front();
               if (rsp_divisor !== want) begin
                  if (misses < 10)
                     $display("%0t: divisor mismatch expected=%h actual=%h",
                              $realtime, want, rsp_divisor);
                  misses++;
               end
            end
         end
      end
      mismatch_count <= misses;
      outstanding <= expected_divisors.size();
   end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int W = bgcd_pkg::FIELD_WIDTH;
   localparam int ITEMS_PER_PHASE = 333;
   localparam int TAIL_CYCLES = 80;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   logic [W-1:0] req_operand_a;
   logic [W-1:0] req_operand_b;
   logic         rsp_valid;
   logic [W-1:0] rsp_divisor;

   int accepted_count;
   int outstanding;
   int mismatch_count;
   int idle_pct;

   binary_gcd uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_divisor   (rsp_divisor)
   );

   gcd_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_valid      (rsp_valid),
      .rsp_divisor    (rsp_divisor),
      .accepted_count (accepted_count),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Present one operand pair and hold it until the block takes it.
   // Random idle cycles go in front according to idle_pct.
   task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b);
      int seen;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_operand_a = a;
      req_operand_b = b;
      seen = accepted_count;
      do @(negedge clock); while (accepted_count == seen);
   endtask

   // Stop sending until every predicted divisor has come back
   task automatic drain;
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Random pair, weighted toward zero operands, shared factors, trailing zeros, near-equal and small values
   task automatic send_random_pair;
      logic [W-1:0] a;
      logic [W-1:0] b;
      logic [W-1:0] g;
      int mode;
      mode = $urandom_range(9);
      case (mode)
         0: begin
            a = $urandom;
            b = ($urandom_range(3) == 0) ? $urandom : '0;
            if ($urandom_range(1)) begin
               g = a;
               a = b;
               b = g;
            end
         end
         4, 5, 6: begin
            // known common factor, sometimes with extra powers of two
            g = $urandom_range(1, 65535) << $urandom_range(0, 8);
            a = g * $urandom_range(0, 32'hFFFF_FFFF / g);
            b = g * $urandom_range(0, 32'hFFFF_FFFF / g);
         end
         7: begin
            a = ($urandom >> $urandom_range(0, 31)) << $urandom_range(0, 31);
            b = ($urandom >> $urandom_range(0, 31)) << $urandom_range(0, 31);
         end
         8: begin
            a = $urandom;
            b = a + $urandom_range(0, 4);
         end
         9: begin
            a = $urandom_range(0, 1000);
            b = $urandom_range(0, 1000);
         end
         default: begin
            a = $urandom;
            b = $urandom;
         end
      endcase
      send_pair(a, b);
   endtask

   // Watchdog
   initial begin
      #2_000_000;
      $display("binary_gcd regression: fail");
      $finish;
   end

   initial begin
      start = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      reset = 1'b1;
      idle_pct = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed: zeros, extremes, powers of two, equal and coprime pairs
      send_pair(32'h0000_0000, 32'h0000_0000);
      send_pair(32'h0000_0000, 32'h1234_5678);
      send_pair(32'h8765_4321, 32'h0000_0000);
      send_pair(32'h0000_0000, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'h0000_0001);
      send_pair(32'h0000_0001, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h4000_0000);
      send_pair(32'h0000_0001, 32'h8000_0000);
      send_pair(32'hFFFF_FFFE, 32'h8000_0000);
      send_pair(32'hC000_0000, 32'h8000_0000);
      send_pair(32'd12, 32'd18);
      send_pair(32'd48, 32'd180);
      send_pair(32'd4294967291, 32'd4294967279);
      send_pair(32'd2147483647, 32'd4294967294);
      send_pair(32'd1, 32'd1);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'h0001_0000, 32'h0000_0100);
      send_pair(32'd1836311903, 32'd2971215073);
      send_pair(32'hDEAD_BEEF, 32'hDEAD_BEEF);
      drain();

      // random phases: sender mostly busy, then mostly idle, then back to back
      idle_pct = 14;
      repeat (ITEMS_PER_PHASE) send_random_pair();
      drain();
      idle_pct = 51;
      repeat (ITEMS_PER_PHASE) send_random_pair();
      drain();
      idle_pct = 0;
      repeat (ITEMS_PER_PHASE) send_random_pair();
      drain();

      // let any stray strobe show up before the verdict
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("binary_gcd regression: pass");
      end else begin
         $display("binary_gcd regression: fail");
      end
      $finish;
   end

endmodule
